// ===== rtl/core/boot_sector_geometry_parser_macros.svh =====
// assertion macros for the boot sector geometry parser
// bodies sample on clk and are disabled while rst_n is low
`ifndef BOOT_SECTOR_GEOMETRY_PARSER_MACROS_SVH
`define BOOT_SECTOR_GEOMETRY_PARSER_MACROS_SVH

// same-cycle implication
`define BSGP_ASSERT_IMPL(label, ant, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error("bsgp assertion failed");

// implication with a fixed delay in cycles
`define BSGP_ASSERT_DELAY(label, ant, n, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> ##(n) (cons)) \
    else $error("bsgp assertion failed");

`endif

// ===== rtl/core/bsgp_pkg.sv =====
// shared types and helpers for the boot sector geometry parser
// no dependencies
package bsgp_pkg;

  localparam logic [1:0] KIND_FAT12 = 2'd0;
  localparam logic [1:0] KIND_FAT16 = 2'd1;
  localparam logic [1:0] KIND_FAT32 = 2'd2;

  localparam logic [7:0]  JUMP_NEAR  = 8'hE9;
  localparam logic [7:0]  JUMP_SHORT = 8'hEB;
  localparam logic [7:0]  JUMP_ALT   = 8'h49;
  localparam logic [7:0]  MEDIA_FLOPPY = 8'hF0;
  localparam logic [7:0]  MEDIA_MIN    = 8'hF8;
  localparam logic [15:0] SECTOR_MIN   = 16'd128;
  localparam logic [15:0] SECTOR_MAX   = 16'd4096;
  localparam logic [31:0] FAT12_MAX_CLUSTERS = 32'd4084;
  localparam logic [31:0] FAT16_MAX_CLUSTERS = 32'd65525;
  localparam int          DIR_ENTRY_SHIFT = 5;  // 32 bytes per directory entry

  // raw parameter block fields as captured
  typedef struct packed {
    logic [7:0]  jump;
    logic [15:0] bps;
    logic [7:0]  spc;
    logic [15:0] reserved;
    logic [7:0]  copies;
    logic [15:0] root_ent;
    logic [15:0] total_small;
    logic [7:0]  media;
    logic [15:0] tsize_small;
    logic [31:0] total_large;
    logic [31:0] tsize_large;
    logic [15:0] version;
    logic [31:0] root_dir_clus;
  } fields_t;

  // values handed from the check stage to the derive stage
  typedef struct packed {
    logic        ok;
    logic [31:0] total;
    logic [15:0] reserved;
    logic [31:0] prod;
    logic [16:0] rds;
    logic [2:0]  spc_sh;
    logic [15:0] tsize_small;
    logic [31:0] tsize_large;
    logic        version_nz;
    logic [15:0] root_ent;
    logic [31:0] root_dir_clus;
    logic [7:0]  copies;
    logic [12:0] sector_bytes;
    logic [19:0] cluster_bytes;
  } stage_t;

  typedef struct packed {
    logic        volume_valid;
    logic [1:0]  fat_kind;
    logic [15:0] reserved_count;
    logic [7:0]  table_copies;
    logic [31:0] table_sectors;
    logic [12:0] sector_bytes;
    logic [19:0] cluster_bytes;
    logic [15:0] root_entries;
    logic [31:0] root_start_cluster;
    logic [31:0] data_clusters;
  } result_t;

  // bit index of a one-hot 16-bit value
  function automatic logic [3:0] onehot_index(input logic [15:0] v);
    logic [3:0] idx;
    idx = '0;
    for (int i = 0; i < 16; i++) begin
      if (v[i]) idx = idx | 4'(i);
    end
    return idx;
  endfunction

endpackage

// ===== rtl/core/bsgp_capture.sv =====
// byte capture stage: places each sector byte into its parameter block field
// depends on bsgp_pkg
module bsgp_capture
  import bsgp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    accept,
  input  logic [7:0] data_byte,
  input  logic    last_byte,
  output logic    snap_valid,
  output fields_t snap
);

  localparam logic [6:0] POS_MAX = 7'd127;

  logic [6:0] pos_r, pos_nxt;
  fields_t    fld_r, fld_nxt, merged;
  fields_t    snap_r, snap_nxt;
  logic       snap_valid_r, snap_valid_nxt;

  // current fields with this byte dropped in at its offset
  always_comb begin
    merged = fld_r;
    case (pos_r)
      7'd0:  merged.jump = data_byte;
      7'd11: merged.bps[7:0] = data_byte;
      7'd12: merged.bps[15:8] = data_byte;
      7'd13: merged.spc = data_byte;
      7'd14: merged.reserved[7:0] = data_byte;
      7'd15: merged.reserved[15:8] = data_byte;
      7'd16: merged.copies = data_byte;
      7'd17: merged.root_ent[7:0] = data_byte;
      7'd18: merged.root_ent[15:8] = data_byte;
      7'd19: merged.total_small[7:0] = data_byte;
      7'd20: merged.total_small[15:8] = data_byte;
      7'd21: merged.media = data_byte;
      7'd22: merged.tsize_small[7:0] = data_byte;
      7'd23: merged.tsize_small[15:8] = data_byte;
      7'd32: merged.total_large[7:0] = data_byte;
      7'd33: merged.total_large[15:8] = data_byte;
      7'd34: merged.total_large[23:16] = data_byte;
      7'd35: merged.total_large[31:24] = data_byte;
      7'd36: merged.tsize_large[7:0] = data_byte;
      7'd37: merged.tsize_large[15:8] = data_byte;
      7'd38: merged.tsize_large[23:16] = data_byte;
      7'd39: merged.tsize_large[31:24] = data_byte;
      7'd42: merged.version[7:0] = data_byte;
      7'd43: merged.version[15:8] = data_byte;
      7'd44: merged.root_dir_clus[7:0] = data_byte;
      7'd45: merged.root_dir_clus[15:8] = data_byte;
      7'd46: merged.root_dir_clus[23:16] = data_byte;
      7'd47: merged.root_dir_clus[31:24] = data_byte;
      default: ;
    endcase
  end

  always_comb begin
    pos_nxt        = pos_r;
    fld_nxt        = fld_r;
    snap_nxt       = snap_r;
    snap_valid_nxt = 1'b0;
    if (accept) begin
      if (last_byte) begin
        // hand the sector off and start over at offset zero
        snap_nxt       = merged;
        snap_valid_nxt = 1'b1;
        fld_nxt        = '0;
        pos_nxt        = '0;
      end else begin
        fld_nxt = merged;
        if (pos_r != POS_MAX) pos_nxt = pos_r + 7'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      fld_r        <= '0;
      snap_valid_r <= 1'b0;
    end else begin
      pos_r        <= pos_nxt;
      fld_r        <= fld_nxt;
      snap_valid_r <= snap_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    snap_r <= snap_nxt;
  end

  assign snap_valid = snap_valid_r;
  assign snap       = snap_r;

endmodule

// ===== rtl/core/bsgp_check.sv =====
// check stage: sanity checks, root sectors, table product, cluster bytes
// depends on bsgp_pkg
module bsgp_check
  import bsgp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    snap_valid,
  input  fields_t snap,
  output logic    stg_valid,
  output stage_t  stg
);

  stage_t     stg_r, stg_nxt;
  logic       stg_valid_r;
  logic       jump_ok, media_ok, bps_ok, spc_ok;
  logic [3:0] bps_sh;
  logic [3:0] spc_idx;
  logic [31:0] tsize;
  logic [39:0] prod_full;
  logic [21:0] rds_num;
  logic [21:0] rds_shifted;
  logic [19:0] cb_shifted;

  always_comb begin
    jump_ok  = (snap.jump == JUMP_NEAR) || (snap.jump == JUMP_SHORT) ||
               (snap.jump == JUMP_ALT);
    media_ok = (snap.media == MEDIA_FLOPPY) || (snap.media >= MEDIA_MIN);
    bps_ok   = (snap.bps >= SECTOR_MIN) && (snap.bps <= SECTOR_MAX) &&
               ((snap.bps & (snap.bps - 16'd1)) == 16'd0);
    spc_ok   = (snap.spc != 8'd0) && ((snap.spc & (snap.spc - 8'd1)) == 8'd0);
    bps_sh   = onehot_index(snap.bps);
    spc_idx  = onehot_index({8'd0, snap.spc});

    tsize     = (snap.tsize_small != 16'd0) ? {16'd0, snap.tsize_small} : snap.tsize_large;
    prod_full = {32'd0, snap.copies} * {8'd0, tsize};

    // ceiling of root directory bytes over sector size, a shift since size is 2^n
    rds_num     = {1'b0, snap.root_ent, 5'd0} + {6'd0, snap.bps} - 22'd1;
    rds_shifted = rds_num >> bps_sh;
    cb_shifted  = {7'd0, snap.bps[12:0]} << spc_idx[2:0];

    stg_nxt.ok = jump_ok && media_ok && bps_ok && spc_ok &&
                 (snap.reserved != 16'd0) && (snap.copies != 8'd0) &&
                 ((snap.total_small != 16'd0) || (snap.total_large != 32'd0));
    stg_nxt.total         = (snap.total_small != 16'd0) ? {16'd0, snap.total_small}
                                                        : snap.total_large;
    stg_nxt.reserved      = snap.reserved;
    stg_nxt.prod          = prod_full[31:0];
    stg_nxt.rds           = rds_shifted[16:0];
    stg_nxt.spc_sh        = spc_idx[2:0];
    stg_nxt.tsize_small   = snap.tsize_small;
    stg_nxt.tsize_large   = snap.tsize_large;
    stg_nxt.version_nz    = (snap.version != 16'd0);
    stg_nxt.root_ent      = snap.root_ent;
    stg_nxt.root_dir_clus = snap.root_dir_clus;
    stg_nxt.copies        = snap.copies;
    stg_nxt.sector_bytes  = snap.bps[12:0];
    stg_nxt.cluster_bytes = cb_shifted;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else begin
      stg_valid_r <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    stg_r <= stg_nxt;
  end

  assign stg_valid = stg_valid_r;
  assign stg       = stg_r;

endmodule

// ===== rtl/core/bsgp_derive.sv =====
// derive stage: cluster count, fat type, final checks, result register
// depends on bsgp_pkg
module bsgp_derive
  import bsgp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    stg_valid,
  input  stage_t  stg,
  output logic    res_valid,
  output result_t res
);

  result_t     res_r, res_nxt;
  logic        res_valid_r;
  logic [31:0] overhead, free_sectors, clusters;
  logic [1:0]  kind;
  logic        good;

  always_comb begin
    overhead     = {16'd0, stg.reserved} + stg.prod + {15'd0, stg.rds};
    free_sectors = stg.total - overhead;
    clusters     = free_sectors >> stg.spc_sh;

    if (clusters <= FAT12_MAX_CLUSTERS) kind = KIND_FAT12;
    else if (clusters <= FAT16_MAX_CLUSTERS) kind = KIND_FAT16;
    else kind = KIND_FAT32;

    good = stg.ok &&
           ((kind == KIND_FAT32) ? ((stg.tsize_large != 32'd0) && !stg.version_nz)
                                 : (stg.tsize_small != 16'd0));

    res_nxt = '0;
    if (good) begin
      res_nxt.volume_valid   = 1'b1;
      res_nxt.fat_kind       = kind;
      res_nxt.reserved_count = stg.reserved;
      res_nxt.table_copies   = stg.copies;
      res_nxt.table_sectors  = (kind == KIND_FAT32) ? stg.tsize_large
                                                    : {16'd0, stg.tsize_small};
      res_nxt.sector_bytes   = stg.sector_bytes;
      res_nxt.cluster_bytes  = stg.cluster_bytes;
      res_nxt.root_entries   = (kind == KIND_FAT32) ? 16'd0 : stg.root_ent;
      res_nxt.root_start_cluster = (kind == KIND_FAT32) ? stg.root_dir_clus : 32'd0;
      res_nxt.data_clusters  = clusters;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else begin
      res_valid_r <= stg_valid;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

// ===== rtl/core/boot_sector_geometry_parser.sv =====
// boot sector geometry parser top level; uses bsgp_pkg, bsgp_capture,
// bsgp_check, bsgp_derive and the assertion macro header
// throughput: one byte per cycle, busy never rises, a new sector may follow at once
// the result strobe follows the last byte taken through the registers in order
// (capture snapshot, check register, result register); the receiver cannot stall
// reset (rst_n low, synchronous) zeroes all captured fields and the byte offset
`include "boot_sector_geometry_parser_macros.svh"

module boot_sector_geometry_parser
  import bsgp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // request side
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  // result side, one-cycle strobe
  output logic        out_valid,
  output logic        out_volume_valid,
  output logic [1:0]  out_fat_kind,
  output logic [15:0] out_reserved_count,
  output logic [7:0]  out_table_copies,
  output logic [31:0] out_table_sectors,
  output logic [12:0] out_sector_bytes,
  output logic [19:0] out_cluster_bytes,
  output logic [15:0] out_root_entries,
  output logic [31:0] out_root_start_cluster,
  output logic [31:0] out_data_clusters
);

  logic    accept;
  logic    snap_valid;
  fields_t snap;
  logic    stg_valid;
  stage_t  stg;
  logic    res_valid;
  result_t res;

  // every stage moves each cycle, so a request is always welcome
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // byte capture into the parameter block fields; snapshot on the last byte
  bsgp_capture u_capture (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .data_byte  (in_data_byte),
    .last_byte  (in_last_byte),
    .snap_valid (snap_valid),
    .snap       (snap)
  );

  // sanity checks, root directory sectors, copies times table size
  bsgp_check u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .snap_valid (snap_valid),
    .snap       (snap),
    .stg_valid  (stg_valid),
    .stg        (stg)
  );

  // cluster count, fat type and the gated result
  bsgp_derive u_derive (
    .clk       (clk),
    .rst_n     (rst_n),
    .stg_valid (stg_valid),
    .stg       (stg),
    .res_valid (res_valid),
    .res       (res)
  );

  assign out_valid              = res_valid;
  assign out_volume_valid       = res.volume_valid;
  assign out_fat_kind           = res.fat_kind;
  assign out_reserved_count     = res.reserved_count;
  assign out_table_copies       = res.table_copies;
  assign out_table_sectors      = res.table_sectors;
  assign out_sector_bytes       = res.sector_bytes;
  assign out_cluster_bytes      = res.cluster_bytes;
  assign out_root_entries       = res.root_entries;
  assign out_root_start_cluster = res.root_start_cluster;
  assign out_data_clusters      = res.data_clusters;

  // a taken last byte always yields a result strobe
  `BSGP_ASSERT_DELAY(a_last_gives_result, accept && in_last_byte, 3, out_valid)
  // no strobe without an earlier taken last byte
  `BSGP_ASSERT_IMPL(a_result_has_cause, out_valid, $past(accept && in_last_byte, 3))
  // a rejected volume carries nothing but zeros
  `BSGP_ASSERT_IMPL(a_invalid_is_zero, out_valid && !out_volume_valid,
    (out_fat_kind == KIND_FAT12) && (out_data_clusters == 32'd0) &&
    (out_cluster_bytes == 20'd0) && (out_sector_bytes == 13'd0) &&
    (out_table_sectors == 32'd0) && (out_reserved_count == 16'd0))
  // an accepted volume has a legal type, a sector size of at least 128, copies and reserved sectors
  `BSGP_ASSERT_IMPL(a_valid_is_sane, out_valid && out_volume_valid,
    (out_fat_kind != 2'd3) && (out_sector_bytes >= 13'd128) &&
    (out_table_copies != 8'd0) && (out_reserved_count != 16'd0))

endmodule

// ===== tb/sector_geometry_checker.sv =====
// result checker for the boot sector geometry parser: rebuilds the parameter block from
// accepted requests, predicts each result and compares it with what the block emits
// depends on bsgp_pkg for the field and result layouts and the FAT constants
module sector_geometry_checker
  import bsgp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  input  logic        out_valid,
  input  logic        out_volume_valid,
  input  logic [1:0]  out_fat_kind,
  input  logic [15:0] out_reserved_count,
  input  logic [7:0]  out_table_copies,
  input  logic [31:0] out_table_sectors,
  input  logic [12:0] out_sector_bytes,
  input  logic [19:0] out_cluster_bytes,
  input  logic [15:0] out_root_entries,
  input  logic [31:0] out_root_start_cluster,
  input  logic [31:0] out_data_clusters,
  output int          mismatches,
  output int          awaited,
  output int          results_seen
);

  localparam logic [7:0] SPC_MAX    = 8'd128;
  localparam logic [6:0] OFFSET_CAP = 7'd127;

  fields_t    bpb;
  logic [6:0] offset;
  result_t    expected_geometry[$];
  result_t    seen;
  result_t    want;

  function automatic fields_t capture_byte(fields_t f, logic [6:0] at, logic [7:0] b);
    fields_t n;
    n = f;
    case (at)
      7'd0:                       n.jump = b;
      7'd11, 7'd12:               n.bps[8*(at-7'd11) +: 8] = b;
      7'd13:                      n.spc = b;
      7'd14, 7'd15:               n.reserved[8*(at-7'd14) +: 8] = b;
      7'd16:                      n.copies = b;
      7'd17, 7'd18:               n.root_ent[8*(at-7'd17) +: 8] = b;
      7'd19, 7'd20:               n.total_small[8*(at-7'd19) +: 8] = b;
      7'd21:                      n.media = b;
      7'd22, 7'd23:               n.tsize_small[8*(at-7'd22) +: 8] = b;
      7'd32, 7'd33, 7'd34, 7'd35: n.total_large[8*(at-7'd32) +: 8] = b;
      7'd36, 7'd37, 7'd38, 7'd39: n.tsize_large[8*(at-7'd36) +: 8] = b;
      7'd42, 7'd43:               n.version[8*(at-7'd42) +: 8] = b;
      7'd44, 7'd45, 7'd46, 7'd47: n.root_dir_clus[8*(at-7'd44) +: 8] = b;
      default: ;
    endcase
    return n;
  endfunction

  function automatic result_t derive_geometry(fields_t f);
    result_t     r;
    logic        ok;
    logic [31:0] bps32;
    logic [31:0] root_secs;
    logic [31:0] fat_secs;
    logic [31:0] total;
    logic [31:0] spare;
    logic [31:0] clusters;
    logic [31:0] prod;
    logic [1:0]  kind;
    r = '0;
    bps32 = {16'd0, f.bps};
    ok = (f.jump == JUMP_NEAR || f.jump == JUMP_SHORT || f.jump == JUMP_ALT) &&
         (f.media == MEDIA_FLOPPY || f.media >= MEDIA_MIN) &&
         f.reserved != 16'd0 && f.copies != 8'd0 &&
         (f.total_small != 16'd0 || f.total_large != 32'd0) &&
         f.bps >= SECTOR_MIN && f.bps <= SECTOR_MAX && (f.bps & (f.bps - 16'd1)) == 16'd0 &&
         f.spc != 8'd0 && f.spc <= SPC_MAX && (f.spc & (f.spc - 8'd1)) == 8'd0;
    if (!ok) return r;
    // root dir sectors rounded up, everything else wraps at 32 bits
    root_secs = (({16'd0, f.root_ent} << DIR_ENTRY_SHIFT) + bps32 - 32'd1) / bps32;
    fat_secs  = f.tsize_small != 16'd0 ? {16'd0, f.tsize_small} : f.tsize_large;
    total     = f.total_small != 16'd0 ? {16'd0, f.total_small} : f.total_large;
    spare     = total - ({16'd0, f.reserved} + {24'd0, f.copies} * fat_secs + root_secs);
    clusters  = spare / {24'd0, f.spc};
    if (clusters <= FAT12_MAX_CLUSTERS) kind = KIND_FAT12;
    else if (clusters <= FAT16_MAX_CLUSTERS) kind = KIND_FAT16;
    else kind = KIND_FAT32;
    if (kind != KIND_FAT32 && f.tsize_small == 16'd0) return r;
    if (kind == KIND_FAT32 && (f.tsize_large == 32'd0 || f.version != 16'd0)) return r;
    prod = {24'd0, f.spc} * bps32;
    r.volume_valid       = 1'b1;
    r.fat_kind           = kind;
    r.reserved_count     = f.reserved;
    r.table_copies       = f.copies;
    r.table_sectors      = kind == KIND_FAT32 ? f.tsize_large : {16'd0, f.tsize_small};
    r.sector_bytes       = f.bps[12:0];
    r.cluster_bytes      = prod[19:0];
    r.root_entries       = kind == KIND_FAT32 ? 16'd0 : f.root_ent;
    r.root_start_cluster = kind == KIND_FAT32 ? f.root_dir_clus : 32'd0;
    r.data_clusters      = clusters;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp, input logic [31:0] act);
    if (exp !== act) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp, act);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      bpb = '0;
      offset = '0;
    end else begin
      // results first: any expectation it matches was queued at an earlier edge
      if (out_valid) begin
        seen = {out_volume_valid, out_fat_kind, out_reserved_count, out_table_copies,
                out_table_sectors, out_sector_bytes, out_cluster_bytes, out_root_entries,
                out_root_start_cluster, out_data_clusters};
        results_seen++;
        if (expected_geometry.size() == 0) begin
          $display("%0t: result with nothing expected, expected none, got %0h", $time, seen);
          mismatches++;
        end else begin
          want = expected_geometry.pop_front();
          check_field("volume_valid", 32'(want.volume_valid), 32'(seen.volume_valid));
          check_field("fat_kind", 32'(want.fat_kind), 32'(seen.fat_kind));
          check_field("reserved_count", 32'(want.reserved_count), 32'(seen.reserved_count));
          check_field("table_copies", 32'(want.table_copies), 32'(seen.table_copies));
          check_field("table_sectors", want.table_sectors, seen.table_sectors);
          check_field("sector_bytes", 32'(want.sector_bytes), 32'(seen.sector_bytes));
          check_field("cluster_bytes", 32'(want.cluster_bytes), 32'(seen.cluster_bytes));
          check_field("root_entries", 32'(want.root_entries), 32'(seen.root_entries));
          check_field("root_start_cluster", want.root_start_cluster, seen.root_start_cluster);
          check_field("data_clusters", want.data_clusters, seen.data_clusters);
        end
      end
      if (start && !busy) begin
        bpb = capture_byte(bpb, offset, in_data_byte);
        if (offset != OFFSET_CAP) offset = offset + 7'd1;
        if (in_last_byte) begin
          expected_geometry.push_back(derive_geometry(bpb));
          bpb = '0;
          offset = '0;
        end
      end
    end
    awaited = expected_geometry.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// top of the boot sector geometry parser testbench: clock, reset, sector stimulus
// and the verdict; depends on bsgp_pkg, the parser and sector_geometry_checker
module tb_top
  import bsgp_pkg::*;
();

  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 10;
  localparam int TARGET_BYTES  = 1900;
  localparam int MIN_SECTORS   = 30;
  localparam int CALM_FROM     = 1600;     // no idling once this many bytes went in
  localparam int DRAIN_LIMIT   = 200;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int IMG_BYTES     = 200;

  // parameter block offsets within the sector
  localparam int OFS_JUMP      = 0;
  localparam int OFS_BPS       = 11;
  localparam int OFS_SPC       = 13;
  localparam int OFS_RESERVED  = 14;
  localparam int OFS_COPIES    = 16;
  localparam int OFS_ROOT_ENT  = 17;
  localparam int OFS_TOTAL16   = 19;
  localparam int OFS_MEDIA     = 21;
  localparam int OFS_FATSZ16   = 22;
  localparam int OFS_TOTAL32   = 32;
  localparam int OFS_FATSZ32   = 36;
  localparam int OFS_VERSION   = 42;
  localparam int OFS_ROOT_CLUS = 44;

  // kinds of sector the random part produces
  typedef enum int {
    STYLE_SMALL_FAT, STYLE_FAT32, STYLE_BOUNDARY, STYLE_BROKEN,
    STYLE_SHORT, STYLE_LONG, STYLE_NOISE
  } style_e;

  // single sanity check knocked out in a broken sector
  typedef enum int {
    FLAW_JUMP, FLAW_MEDIA, FLAW_NO_RESERVED, FLAW_NO_COPIES,
    FLAW_NO_TOTAL, FLAW_BPS_RANDOM, FLAW_SPC_RANDOM, FLAW_BPS_RANGE
  } flaw_e;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [7:0]  in_data_byte;
  logic        in_last_byte;
  logic        out_valid;
  logic        out_volume_valid;
  logic [1:0]  out_fat_kind;
  logic [15:0] out_reserved_count;
  logic [7:0]  out_table_copies;
  logic [31:0] out_table_sectors;
  logic [12:0] out_sector_bytes;
  logic [19:0] out_cluster_bytes;
  logic [15:0] out_root_entries;
  logic [31:0] out_root_start_cluster;
  logic [31:0] out_data_clusters;

  int mismatches;
  int awaited;
  int results_seen;
  int cycle_count;
  int bytes_sent;
  int sectors_sent;
  bit calm;

  // sector image being sent, offsets past 127 only matter for long sectors
  logic [7:0] sector_img [0:IMG_BYTES-1];

  boot_sector_geometry_parser dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .start                  (start),
    .busy                   (busy),
    .in_data_byte           (in_data_byte),
    .in_last_byte           (in_last_byte),
    .out_valid              (out_valid),
    .out_volume_valid       (out_volume_valid),
    .out_fat_kind           (out_fat_kind),
    .out_reserved_count     (out_reserved_count),
    .out_table_copies       (out_table_copies),
    .out_table_sectors      (out_table_sectors),
    .out_sector_bytes       (out_sector_bytes),
    .out_cluster_bytes      (out_cluster_bytes),
    .out_root_entries       (out_root_entries),
    .out_root_start_cluster (out_root_start_cluster),
    .out_data_clusters      (out_data_clusters)
  );

  // watches both channels, predicts and compares on its own
  sector_geometry_checker u_checker (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .start                  (start),
    .busy                   (busy),
    .in_data_byte           (in_data_byte),
    .in_last_byte           (in_last_byte),
    .out_valid              (out_valid),
    .out_volume_valid       (out_volume_valid),
    .out_fat_kind           (out_fat_kind),
    .out_reserved_count     (out_reserved_count),
    .out_table_copies       (out_table_copies),
    .out_table_sectors      (out_table_sectors),
    .out_sector_bytes       (out_sector_bytes),
    .out_cluster_bytes      (out_cluster_bytes),
    .out_root_entries       (out_root_entries),
    .out_root_start_cluster (out_root_start_cluster),
    .out_data_clusters      (out_data_clusters),
    .mismatches             (mismatches),
    .awaited                (awaited),
    .results_seen           (results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // watchdog: a hung handshake or a lost result ends the run here
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("%0t: cycle limit reached with %0d results outstanding", $time, awaited);
    $display("TEST FAILED");
    $finish;
  end

  // little-endian field into the image
  task automatic put_le(input int ofs, input int nbytes, input logic [31:0] v);
    for (int i = 0; i < nbytes; i++) sector_img[ofs + i] = v[8*i +: 8];
  endtask

  // one request: optional idle burst, then hold start until the block takes the byte
  task automatic send_byte(input logic [7:0] value, input logic is_last);
    int gap;
    if (!calm && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 11);
      @(negedge clk);
      start        <= 1'b0;
      in_data_byte <= 8'($urandom);   // junk while idle must be ignored
      in_last_byte <= 1'($urandom);
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start        <= 1'b1;
    in_data_byte <= value;
    in_last_byte <= is_last;
    // busy is stable between edges, so this is what the next rising edge sees
    while (busy) @(negedge clk);
    @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_sector(input int len);
    for (int i = 0; i < len; i++) send_byte(sector_img[i], i == len - 1);
    sectors_sent++;
  endtask

  // clean image with a known overhead of two sectors, so the cluster count is exact
  task automatic build_boundary(input logic [31:0] clusters);
    for (int i = 0; i < IMG_BYTES; i++) sector_img[i] = 8'h00;
    put_le(OFS_JUMP, 1, 32'(JUMP_NEAR));
    put_le(OFS_BPS, 2, 32'd512);
    put_le(OFS_SPC, 1, 32'd1);
    put_le(OFS_RESERVED, 2, 32'd1);
    put_le(OFS_COPIES, 1, 32'd1);
    put_le(OFS_TOTAL16, 2, clusters + 32'd2);
    put_le(OFS_MEDIA, 1, 32'(MEDIA_MIN));
    put_le(OFS_FATSZ16, 2, 32'd1);
    put_le(OFS_FATSZ32, 4, 32'd7);
    put_le(OFS_ROOT_CLUS, 4, 32'd2);
  endtask

  // random noise everywhere, then a header that passes the common checks
  task automatic sane_header();
    logic [7:0] jump;
    for (int i = 0; i < IMG_BYTES; i++) sector_img[i] = 8'($urandom);
    case ($urandom_range(0, 2))
      0:       jump = JUMP_NEAR;
      1:       jump = JUMP_SHORT;
      default: jump = JUMP_ALT;
    endcase
    put_le(OFS_JUMP, 1, 32'(jump));
    put_le(OFS_BPS, 2, 32'd1 << $urandom_range(7, 12));
    put_le(OFS_SPC, 1, 32'd1 << $urandom_range(0, 7));
    put_le(OFS_RESERVED, 2, $urandom_range(0, 15) == 0 ? $urandom_range(1, 65535)
                                                     : $urandom_range(1, 32));
    put_le(OFS_COPIES, 1, $urandom_range(0, 7) == 0 ? $urandom_range(1, 255)
                                                  : $urandom_range(1, 2));
    put_le(OFS_ROOT_ENT, 2, $urandom_range(0, 7) == 0 ? $urandom_range(0, 65535)
                                                    : $urandom_range(0, 1023));
    put_le(OFS_MEDIA, 1, $urandom_range(0, 3) == 0 ? 32'(MEDIA_FLOPPY)
                                                 : 32'(MEDIA_MIN) + $urandom_range(0, 7));
  endtask

  // fat12/16 layout: small total and small table size
  task automatic small_fat_fields();
    put_le(OFS_TOTAL16, 2, $urandom_range(0, 3) == 0 ? $urandom_range(1, 65535)
                                                   : $urandom_range(100, 20000));
    put_le(OFS_FATSZ16, 2, $urandom_range(0, 15) == 0 ? 0 : $urandom_range(1, 64));
  endtask

  // fat32 layout: large total and table size, version and root cluster
  task automatic fat32_fields();
    put_le(OFS_TOTAL16, 2, $urandom_range(0, 7) == 0 ? $urandom_range(1, 65535) : 0);
    put_le(OFS_FATSZ16, 2, $urandom_range(0, 7) == 0 ? $urandom_range(1, 255) : 0);
    put_le(OFS_TOTAL32, 4, $urandom_range(0, 3) == 0 ? $urandom
                                                   : $urandom_range(32'h10000, 32'h0FFFFFFF));
    put_le(OFS_FATSZ32, 4, $urandom_range(0, 15) == 0 ? 0 : $urandom_range(1, 16384));
    put_le(OFS_VERSION, 2, $urandom_range(0, 7) == 0 ? $urandom_range(0, 65535) : 0);
    put_le(OFS_ROOT_CLUS, 4, $urandom);
  endtask

  task automatic make_sector(input style_e style, output int len);
    flaw_e flaw;
    case (style)
      STYLE_SMALL_FAT: begin
        sane_header();
        small_fat_fields();
        len = $urandom_range(24, 64);
      end
      STYLE_FAT32: begin
        sane_header();
        fat32_fields();
        len = $urandom_range(48, 72);
      end
      STYLE_BOUNDARY: begin
        // straddle the fat12/fat16 and fat16/fat32 limits
        build_boundary(($urandom_range(0, 1) ? FAT12_MAX_CLUSTERS : FAT16_MAX_CLUSTERS)
                       + $urandom_range(0, 4) - 2);
        len = $urandom_range(48, 64);
      end
      STYLE_BROKEN: begin
        sane_header();
        if ($urandom_range(0, 1)) small_fat_fields();
        else fat32_fields();
        flaw = flaw_e'($urandom_range(0, 7));
        case (flaw)
          FLAW_JUMP:        put_le(OFS_JUMP, 1, $urandom);
          FLAW_MEDIA:       put_le(OFS_MEDIA, 1, $urandom_range(0, 32'hF7));
          FLAW_NO_RESERVED: put_le(OFS_RESERVED, 2, 0);
          FLAW_NO_COPIES:   put_le(OFS_COPIES, 1, 0);
          FLAW_NO_TOTAL: begin
            put_le(OFS_TOTAL16, 2, 0);
            put_le(OFS_TOTAL32, 4, 0);
          end
          FLAW_BPS_RANDOM:  put_le(OFS_BPS, 2, $urandom);
          FLAW_SPC_RANDOM:  put_le(OFS_SPC, 1, $urandom);
          FLAW_BPS_RANGE:   put_le(OFS_BPS, 2, $urandom_range(0, 1) ? 32'd64 : 32'd8192);
          default: ;
        endcase
        len = $urandom_range(48, 64);
      end
      STYLE_SHORT: begin
        // the sector ends before some fields arrive, they must read as zero
        sane_header();
        fat32_fields();
        len = $urandom_range(1, 47);
      end
      STYLE_LONG: begin
        // bytes past offset 126 must not land anywhere
        sane_header();
        small_fat_fields();
        len = $urandom_range(128, IMG_BYTES);
      end
      default: begin
        for (int i = 0; i < IMG_BYTES; i++) sector_img[i] = 8'($urandom);
        len = $urandom_range(1, 40);
      end
    endcase
  endtask

  initial begin
    int     len;
    int     pick;
    int     waited;
    style_e style;

    rst_n        = 1'b0;
    start        = 1'b0;
    in_data_byte = 8'h00;
    in_last_byte = 1'b0;
    calm         = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // --- directed sectors ---

    // lone marked byte: every other field reads as zero, so invalid
    sector_img[0] = JUMP_SHORT;
    send_sector(1);

    // cluster counts right on both sides of each fat type limit
    build_boundary(FAT12_MAX_CLUSTERS);
    send_sector(48);
    build_boundary(FAT12_MAX_CLUSTERS + 32'd1);
    send_sector(48);
    build_boundary(FAT16_MAX_CLUSTERS);
    send_sector(48);
    build_boundary(FAT16_MAX_CLUSTERS + 32'd1);
    send_sector(48);

    // largest geometry, all-ones fields, 32-bit wrap in the overhead sum
    build_boundary(32'd0);
    put_le(OFS_JUMP, 1, 32'(JUMP_ALT));
    put_le(OFS_MEDIA, 1, 32'(MEDIA_FLOPPY));
    put_le(OFS_BPS, 2, 32'(SECTOR_MAX));
    put_le(OFS_SPC, 1, 32'd128);
    put_le(OFS_RESERVED, 2, 32'hFFFF);
    put_le(OFS_COPIES, 1, 32'hFF);
    put_le(OFS_ROOT_ENT, 2, 32'hFFFF);
    put_le(OFS_TOTAL16, 2, 0);
    put_le(OFS_FATSZ16, 2, 0);
    put_le(OFS_TOTAL32, 4, 32'hFFFFFFFF);
    put_le(OFS_FATSZ32, 4, 32'hFFFFFFFF);
    put_le(OFS_ROOT_CLUS, 4, 32'hFFFFFFFF);
    send_sector(48);

    // smallest sizes with a total far below the overhead
    build_boundary(32'd0);
    put_le(OFS_BPS, 2, 32'(SECTOR_MIN));
    put_le(OFS_RESERVED, 2, 32'hFFFF);
    put_le(OFS_COPIES, 1, 32'hFF);
    put_le(OFS_ROOT_ENT, 2, 32'hFFFF);
    put_le(OFS_TOTAL16, 2, 32'd1);
    put_le(OFS_FATSZ16, 2, 32'hFFFF);
    send_sector(48);

    // power of two but too large a sector, then bad jump and media bytes
    build_boundary(32'd300);
    put_le(OFS_BPS, 2, 32'd8192);
    send_sector(24);
    build_boundary(32'd300);
    put_le(OFS_JUMP, 1, 32'hEA);
    put_le(OFS_MEDIA, 1, 32'hF7);
    send_sector(24);

    // long sector with nonzero tail bytes
    build_boundary(32'd100);
    for (int i = 48; i < 150; i++) sector_img[i] = 8'hFF;
    send_sector(150);

    // --- random sectors, mostly well formed ---
    while (bytes_sent < TARGET_BYTES || sectors_sent < MIN_SECTORS) begin
      calm = (bytes_sent >= CALM_FROM);
      pick = $urandom_range(0, 19);
      if (pick < 7) style = STYLE_SMALL_FAT;
      else if (pick < 13) style = STYLE_FAT32;
      else if (pick < 15) style = STYLE_BOUNDARY;
      else if (pick < 17) style = STYLE_BROKEN;
      else if (pick == 17) style = STYLE_SHORT;
      else if (pick == 18) style = STYLE_LONG;
      else style = STYLE_NOISE;
      make_sector(style, len);
      send_sector(len);
    end

    @(negedge clk);
    start <= 1'b0;

    // drain outstanding results, then give stray strobes a chance to show
    waited = 0;
    while (awaited != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    if (awaited != 0)
      $display("%0t: %0d expected results never arrived", $time, awaited);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("covered %0d sectors in %0d bytes, %0d results compared, %0d mismatches",
             sectors_sent, bytes_sent, results_seen, mismatches);
    $display("mix: fat12/16/32 layouts, type limits, broken checks, short/long/noise sectors");
    if (mismatches == 0 && awaited == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/bsgp_pkg.sv
rtl/core/bsgp_capture.sv
rtl/core/bsgp_check.sv
rtl/core/bsgp_derive.sv
rtl/core/boot_sector_geometry_parser.sv
tb/sector_geometry_checker.sv
tb/tb_top.sv
